/* rtl/core/rcss_pkg.sv */
`default_nettype none
package rcss_pkg;

  // Band of channels 11..26 held as a 16-bit set
  localparam int BAND_LO       = 11;
  localparam int BAND_W        = 16;
  localparam int BAND_IDX_W    = 4;
  localparam int CHAN_W        = 5;
  localparam int TOTAL_W       = 16;
  localparam int DWELL_W       = 16;
  localparam int TPS_W         = 10;
  localparam int TICKS_W       = 16;
  localparam int COUNT_W       = 5;
  localparam int PROD_W        = DWELL_W + TPS_W;
  localparam int DIV_NUM_W     = TOTAL_W;
  localparam int DIV_DEN_W     = COUNT_W;
  localparam int DIV_CNT_W     = 4;
  localparam int MS_PER_SECOND = 1000;
  localparam int TPS_RESET     = 125;

  // Divide by 1000 as a shift by 3 and a multiply by the reciprocal of 125;
  // exact for every product below 2^26
  localparam int TICK_SHIFT    = 3;
  localparam int SCALED_W      = PROD_W - TICK_SHIFT;
  localparam int RECIP_W       = 24;
  localparam int RECIP_SHIFT   = 30;
  localparam logic [RECIP_W-1:0] TICK_RECIP = 24'd8589935;
  localparam int TICK_Q_W      = SCALED_W + RECIP_W - RECIP_SHIFT;

  typedef enum logic [1:0] {
    MODE_START    = 2'd0,
    MODE_EVENT    = 2'd1,
    MODE_DISCOVER = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_NO_CHANNELS = 2'd1,
    STATUS_BUSY        = 2'd2,
    STATUS_SHORT       = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic mul_load;
    logic tick_load;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_scan_div;
    logic need_tick;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

/* rtl/core/rcss_div.sv */
`default_nettype none
module rcss_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [rcss_pkg::DIV_NUM_W-1:0] num,
  input  wire logic [rcss_pkg::DIV_DEN_W-1:0] den,
  output logic      [rcss_pkg::DIV_NUM_W-1:0] quo,
  output logic                                done
);
  import rcss_pkg::*;

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] divisor;
  logic [DIV_CNT_W-1:0] count;
  logic                 busy;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  // Shift in one dividend bit and try the subtract
  assign trial = {rem, quo[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  // Control of the iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == DIV_CNT_W'(DIV_NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      divisor <= den;
    end else if (busy) begin
      if (fits) begin
        rem <= DIV_DEN_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DIV_DEN_W-1:0];
      end
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rcss_dp.sv */
`default_nettype none
module rcss_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire rcss_pkg::cmd_t               cmd,
  output rcss_pkg::dp_status_t              st,
  input  wire logic [1:0]                   mode,
  input  wire logic [31:0]                  requested_channels,
  input  wire logic [rcss_pkg::TOTAL_W-1:0] total_time_ms,
  input  wire logic                         radio_fault,
  input  wire logic                         cfg_valid,
  input  wire logic [rcss_pkg::TPS_W-1:0]   cfg_data,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output logic [1:0]                        status,
  output logic [rcss_pkg::CHAN_W-1:0]       tune_channel,
  output logic                              tune_valid,
  output logic [rcss_pkg::TICKS_W-1:0]      dwell_ticks,
  output logic                              send_beacon_request,
  output logic                              scan_done
);
  import rcss_pkg::*;

  logic [TPS_W-1:0]     tps;
  logic [BAND_W-1:0]    remaining;
  logic [BAND_W-1:0]    remaining_next;
  logic [DWELL_W-1:0]   dwell_ms;
  logic [DWELL_W-1:0]   dwell_ms_next;
  mode_t                cap_mode;
  logic [BAND_W-1:0]    cap_mask;
  logic [TOTAL_W-1:0]   cap_total;
  logic                 cap_fault;
  logic [PROD_W-1:0]    product;
  logic [SCALED_W+RECIP_W-1:0] recip_prod;
  logic [TICK_Q_W-1:0]  tick_quo;
  logic [COUNT_W-1:0]   chan_count;
  logic [BAND_W-1:0]    low_bit;
  logic [BAND_IDX_W-1:0] low_idx;
  logic                 busy;
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_quo;
  logic                 div_done;
  status_t              status_c;
  logic [CHAN_W-1:0]    chan_c;
  logic                 tvalid_c;
  logic [TICKS_W-1:0]   ticks_c;
  logic                 beacon_c;
  logic                 done_c;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tps <= TPS_W'(TPS_RESET);
    end else if (cfg_valid) begin
      tps <= cfg_data;
    end
  end

  // Scale dwell by the tick rate, then divide by 1000 through the reciprocal
  assign recip_prod = product[PROD_W-1:TICK_SHIFT] * TICK_RECIP;

  // Capture the request word, masked to the band; load the product and tick quotient
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_mode  <= mode_t'(mode);
      cap_mask  <= requested_channels[BAND_LO +: BAND_W];
      cap_total <= total_time_ms;
      cap_fault <= radio_fault;
    end
    if (cmd.mul_load) begin
      product <= dwell_ms * tps;
    end
    if (cmd.tick_load) begin
      tick_quo <= recip_prod[RECIP_SHIFT +: TICK_Q_W];
    end
  end

  assign busy       = remaining != '0;
  assign chan_count = COUNT_W'($countones(cap_mask));
  assign low_bit    = remaining & (~remaining + 1'b1);

  // Encode the lowest remaining channel
  always_comb begin
    low_idx = '0;
    for (int i = 0; i < BAND_W; i++) begin
      if (low_bit[i]) begin
        low_idx = BAND_IDX_W'(i);
      end
    end
  end

  // Divider for the dwell split
  assign div_start = cmd.div_start;

  rcss_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (cap_total),
    .den   (chan_count),
    .quo   (div_quo),
    .done  (div_done)
  );

  // Result word and next scan state
  always_comb begin
    status_c       = STATUS_OK;
    chan_c         = '0;
    tvalid_c       = 1'b0;
    ticks_c        = '0;
    beacon_c       = 1'b0;
    done_c         = 1'b0;
    remaining_next = remaining;
    dwell_ms_next  = dwell_ms;
    case (cap_mode)
      MODE_START: begin
        if (cap_mask == '0) begin
          status_c = STATUS_NO_CHANNELS;
        end else if (busy) begin
          status_c = STATUS_BUSY;
        end else if (div_quo[DWELL_W-1:0] == '0) begin
          status_c = STATUS_SHORT;
        end else begin
          remaining_next = cap_mask;
          dwell_ms_next  = div_quo[DWELL_W-1:0];
        end
      end
      MODE_EVENT: begin
        if (busy && !cap_fault) begin
          remaining_next = remaining & ~low_bit;
          chan_c   = CHAN_W'({1'b0, low_idx} + CHAN_W'(BAND_LO));
          tvalid_c = 1'b1;
          beacon_c = 1'b1;
          if (tick_quo[TICK_Q_W-1:TICKS_W] != '0) begin
            ticks_c = '1;
          end else begin
            ticks_c = tick_quo[TICKS_W-1:0];
          end
        end else begin
          remaining_next = '0;
          dwell_ms_next  = '0;
          done_c         = 1'b1;
        end
      end
      MODE_DISCOVER: begin
        if (busy) begin
          status_c = STATUS_BUSY;
        end else begin
          beacon_c = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      dwell_ms <= '0;
    end else if (cmd.commit) begin
      remaining <= remaining_next;
      dwell_ms <= dwell_ms_next;
    end
  end

  // Output register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status              <= status_c;
      tune_channel        <= chan_c;
      tune_valid          <= tvalid_c;
      dwell_ticks         <= ticks_c;
      send_beacon_request <= beacon_c;
      scan_done           <= done_c;
    end
  end

  assign st.need_scan_div = (cap_mode == MODE_START) && (cap_mask != '0) && !busy;
  assign st.need_tick     = (cap_mode == MODE_EVENT) && busy && !cap_fault;
  assign st.div_done      = div_done;
  assign st.out_free      = !rsp_valid || !rsp_stall;

`ifndef NO_ASSERTIONS
  a_tune_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && tune_valid |-> send_beacon_request && !scan_done && status == STATUS_OK)
    else $error("tune word without beacon request or with done");
  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && cap_mode == MODE_START && status_c == STATUS_OK |=> remaining != '0)
    else $error("accepted start left no channels");
`endif

endmodule
`default_nettype wire

/* rtl/core/rcss_ctrl.sv */
`default_nettype none
module rcss_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire rcss_pkg::dp_status_t st,
  output rcss_pkg::cmd_t            cmd
);
  import rcss_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (st.need_scan_div) begin
          state_next = ST_DIV_WAIT;
        end else if (st.need_tick) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_MUL: begin
        state_next = ST_FINISH;
      end
      ST_DIV_WAIT: begin
        if (st.div_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath
  always_comb begin
    req_stall     = 1'b1;
    cmd.capture   = 1'b0;
    cmd.div_start = 1'b0;
    cmd.mul_load  = 1'b0;
    cmd.tick_load = 1'b0;
    cmd.commit    = 1'b0;
    case (state)
      ST_IDLE: begin
        req_stall   = 1'b0;
        cmd.capture = req_valid;
      end
      ST_DECODE: begin
        cmd.div_start = st.need_scan_div;
        cmd.mul_load  = !st.need_scan_div && st.need_tick;
      end
      ST_MUL: begin
        cmd.tick_load = 1'b1;
      end
      ST_DIV_WAIT: begin
      end
      ST_FINISH: begin
        cmd.commit = st.out_free;
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    st.div_done |-> state == ST_DIV_WAIT)
    else $error("divider finished outside wait state");
  a_mul_to_finish: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |=> state == ST_FINISH)
    else $error("multiply step not followed by finish");
`endif

endmodule
`default_nettype wire

/* rtl/core/radio_channel_scan_sequencer.sv */
// Channel  Handshake              Word
// req      req_valid / req_stall  mode, requested_channels, total_time_ms, radio_fault
// rsp      rsp_valid / rsp_stall  status, tune_channel, tune_valid, dwell_ticks,
//                                 send_beacon_request, scan_done
// cfg      cfg_valid / cfg_ready  cfg_data = ticks_per_second
//
// One word at a time, accept to result: decode, then a multiply state for a scan step
// (dwell times rate, then a reciprocal multiply for /1000) or the 16-iteration divider
// for a start that reaches the dwell split, then finish; the next word waits for idle.
// A new request word is taken while the previous result still waits in the output
// register; the result is loaded once that register frees.
// Reset (rst, synchronous) clears the scan state and sets ticks_per_second to 125.
`default_nettype none
module radio_channel_scan_sequencer (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire logic [1:0]                   mode,
  input  wire logic [31:0]                  requested_channels,
  input  wire logic [rcss_pkg::TOTAL_W-1:0] total_time_ms,
  input  wire logic                         radio_fault,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output logic [1:0]                        status,
  output logic [rcss_pkg::CHAN_W-1:0]       tune_channel,
  output logic                              tune_valid,
  output logic [rcss_pkg::TICKS_W-1:0]      dwell_ticks,
  output logic                              send_beacon_request,
  output logic                              scan_done,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [rcss_pkg::TPS_W-1:0]   cfg_data
);
  import rcss_pkg::*;

  cmd_t       cmd;
  dp_status_t st;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  rcss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  rcss_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .st                  (st),
    .mode                (mode),
    .requested_channels  (requested_channels),
    .total_time_ms       (total_time_ms),
    .radio_fault         (radio_fault),
    .cfg_valid           (cfg_valid),
    .cfg_data            (cfg_data),
    .rsp_valid           (rsp_valid),
    .rsp_stall           (rsp_stall),
    .status              (status),
    .tune_channel        (tune_channel),
    .tune_valid          (tune_valid),
    .dwell_ticks         (dwell_ticks),
    .send_beacon_request (send_beacon_request),
    .scan_done           (scan_done)
  );

endmodule
`default_nettype wire

/* verif/tb_radio_channel_scan_sequencer.sv */
module tb_radio_channel_scan_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import rcss_pkg::*;

  localparam logic [31:0] BAND_MASK = 32'h07FF_F800;
  localparam int          N_PHASES  = 8;
  localparam int          PHASE_WORDS = 138;

  typedef struct packed {
    mode_t               mode;
    logic [31:0]         chans;
    logic [TOTAL_W-1:0]  total;
    logic                fault;
  } scan_word_t;

  typedef struct packed {
    status_t             status;
    logic [CHAN_W-1:0]   chan;
    logic                tvalid;
    logic [TICKS_W-1:0]  ticks;
    logic                beacon;
    logic                done;
  } scan_result_t;

  typedef enum logic {
    ROW_WORD,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    scan_word_t   word;
    logic [9:0]   cfg_val;
    logic         lit;
    scan_result_t result;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  logic [1:0]           mode = 2'd0;
  logic [31:0]          requested_channels = 32'd0;
  logic [TOTAL_W-1:0]   total_time_ms = '0;
  logic                 radio_fault = 1'b0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  logic [1:0]           status;
  logic [CHAN_W-1:0]    tune_channel;
  logic                 tune_valid;
  logic [TICKS_W-1:0]   dwell_ticks;
  logic                 send_beacon_request;
  logic                 scan_done;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [TPS_W-1:0]     cfg_data = '0;

  // Predictor state: channels left in the scan, dwell and tick rate
  logic [31:0]          scan_left = '0;
  logic [DWELL_W-1:0]   scan_dwell_ms = '0;
  int unsigned          tick_rate = TPS_RESET;

  scan_result_t         pending_results[$];
  dir_row_t             dir_rows[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_left      = 0;
  int errors         = 0;
  int words_sent     = 0;
  int results_seen   = 0;
  int scans_started  = 0;
  int scans_aborted  = 0;
  int rates_used     = 0;

  int ph_tps [N_PHASES] = '{1000, 1, 1023, 0, -1, 125, -1, 500};

  radio_channel_scan_sequencer u_top (
    .clk                 (clk),
    .rst                 (rst),
    .req_valid           (req_valid),
    .req_stall           (req_stall),
    .mode                (mode),
    .requested_channels  (requested_channels),
    .total_time_ms       (total_time_ms),
    .radio_fault         (radio_fault),
    .rsp_valid           (rsp_valid),
    .rsp_stall           (rsp_stall),
    .status              (status),
    .tune_channel        (tune_channel),
    .tune_valid          (tune_valid),
    .dwell_ticks         (dwell_ticks),
    .send_beacon_request (send_beacon_request),
    .scan_done           (scan_done),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Compute the result of one request word and advance the scan state
  function automatic scan_result_t scan_predict(scan_word_t w);
    scan_result_t     r;
    logic [31:0]      band;
    int unsigned      n;
    int unsigned      d;
    int               c;
    longint unsigned  t;
    r = '0;
    band = w.chans & BAND_MASK;
    case (w.mode)
      MODE_START: begin
        if (band == 0) begin
          r.status = STATUS_NO_CHANNELS;
        end else if (scan_left != 0) begin
          r.status = STATUS_BUSY;
        end else begin
          n = $countones(band);
          d = w.total / n;
          if (d == 0) begin
            r.status = STATUS_SHORT;
          end else begin
            scan_left = band;
            scan_dwell_ms = d[DWELL_W-1:0];
            scans_started++;
          end
        end
      end
      MODE_EVENT: begin
        if (scan_left != 0) begin
          c = 0;
          while (c < 31 && !scan_left[c]) c++;
          scan_left[c] = 1'b0;
          if (w.fault) begin
            // abort: the channel is consumed but never tuned
            scan_left = '0;
            scan_dwell_ms = '0;
            r.done = 1'b1;
            scans_aborted++;
          end else begin
            t = 64'(scan_dwell_ms);
            t = t * tick_rate / MS_PER_SECOND;
            r.chan = c[CHAN_W-1:0];
            r.tvalid = 1'b1;
            r.ticks = (t > 64'hFFFF) ? 16'hFFFF : t[15:0];
            r.beacon = 1'b1;
          end
        end else begin
          scan_left = '0;
          scan_dwell_ms = '0;
          r.done = 1'b1;
        end
      end
      MODE_DISCOVER: begin
        if (scan_left != 0) r.status = STATUS_BUSY;
        else r.beacon = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic scan_word_t wd(mode_t m, logic [31:0] c, logic [15:0] t, logic f);
    scan_word_t w;
    w.mode = m;
    w.chans = c;
    w.total = t;
    w.fault = f;
    return w;
  endfunction

  function automatic scan_result_t res(status_t s, int c, logic tv, int t, logic b, logic d);
    scan_result_t r;
    r.status = s;
    r.chan = c[CHAN_W-1:0];
    r.tvalid = tv;
    r.ticks = t[TICKS_W-1:0];
    r.beacon = b;
    r.done = d;
    return r;
  endfunction

  function automatic void add_word(scan_word_t w, logic lit, scan_result_t r);
    dir_row_t row;
    row = '0;
    row.kind = ROW_WORD;
    row.word = w;
    row.lit = lit;
    row.result = r;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(int v);
    dir_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.cfg_val = v[9:0];
    dir_rows.push_back(row);
  endfunction

  // Random word: mostly well-formed scans, the rest noise and misuse
  function automatic scan_word_t next_word();
    scan_word_t   w;
    int           pick;
    logic [15:0]  band;
    int           n;
    w.chans = $urandom;
    w.total = TOTAL_W'($urandom_range(65535, 0));
    w.fault = 1'($urandom_range(1, 0));
    pick = $urandom_range(99, 0);
    band = 16'($urandom);
    if ($urandom_range(1, 0)) band = band & 16'($urandom) & 16'($urandom);
    if (band == 0) band = 16'h1 << $urandom_range(15, 0);
    n = $countones(band);
    if (scan_left == 0) begin
      if (pick < 75) begin
        w.mode = MODE_START;
        w.chans[26:11] = band;
        case ($urandom_range(3, 0))
          0: w.total = 16'hFFFF;
          1: w.total = TOTAL_W'($urandom_range(4 * n, n));
          default: ;
        endcase
      end else if (pick < 80) begin
        w.mode = MODE_START;
        w.chans[26:11] = '0;
      end else if (pick < 85) begin
        w.mode = MODE_START;
        w.chans[26:11] = band;
        w.total = TOTAL_W'($urandom_range(n - 1, 0));
      end else if (pick < 92) begin
        w.mode = MODE_DISCOVER;
      end else if (pick < 96) begin
        w.mode = MODE_EVENT;
      end else begin
        w.mode = MODE_NONE;
      end
    end else begin
      if (pick < 80) begin
        w.mode = MODE_EVENT;
        w.fault = ($urandom_range(99, 0) < 4);
      end else if (pick < 88) begin
        w.mode = MODE_START;
      end else if (pick < 95) begin
        w.mode = MODE_DISCOVER;
      end else begin
        w.mode = MODE_NONE;
      end
    end
    return w;
  endfunction

  // Offer one word, hold it until accepted, then queue its result
  task automatic send_word(scan_word_t w, logic lit, scan_result_t lit_res);
    scan_result_t p;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid          <= 1'b1;
    mode               <= w.mode;
    requested_channels <= w.chans;
    total_time_ms      <= w.total;
    radio_fault        <= w.fault;
    do @(posedge clk); while (req_stall);
    p = scan_predict(w);
    pending_results.push_back(lit ? lit_res : p);
    if (w.mode != MODE_NONE) words_sent++;
  endtask

  // Drop valid and wait until every queued result has drained
  task automatic drain_results();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the tick rate while the block is idle
  task automatic write_tps(int v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v[TPS_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    tick_rate = v & 10'h3FF;
    rates_used++;
    cfg_valid <= 1'b0;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Receiver stall: long hold-off when requested, otherwise random
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else begin
      rsp_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : rsp_check
    scan_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result word with no request pending");
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, status);
        check_field("tune_channel", want.chan, tune_channel);
        check_field("tune_valid", want.tvalid, tune_valid);
        check_field("dwell_ticks", want.ticks, dwell_ticks);
        check_field("send_beacon_request", want.beacon, send_beacon_request);
        check_field("scan_done", want.done, scan_done);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("[radio_channel_scan_sequencer] ERROR");
    $finish;
  end

  initial begin
    scan_word_t w;
    int         p;
    int         k;
    int         v;

    // Directed words at the reset tick rate
    add_word(wd(MODE_EVENT, 32'h0, 16'h0, 1'b0), 1'b1, res(STATUS_OK, 0, 0, 0, 0, 1));
    add_word(wd(MODE_DISCOVER, 32'hFFFF_FFFF, 16'hFFFF, 1'b1), 1'b1,
             res(STATUS_OK, 0, 0, 0, 1, 0));
    add_word(wd(MODE_NONE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1), 1'b1,
             res(STATUS_OK, 0, 0, 0, 0, 0));
    add_word(wd(MODE_START, 32'h0, 16'hFFFF, 1'b0), 1'b1,
             res(STATUS_NO_CHANNELS, 0, 0, 0, 0, 0));
    add_word(wd(MODE_START, 32'hF800_07FF, 16'hFFFF, 1'b1), 1'b1,
             res(STATUS_NO_CHANNELS, 0, 0, 0, 0, 0));
    add_word(wd(MODE_START, BAND_MASK, 16'd15, 1'b0), 1'b1,
             res(STATUS_SHORT, 0, 0, 0, 0, 0));
    add_word(wd(MODE_START, 32'hFFFF_FFFF, 16'hFFFF, 1'b0), 1'b1,
             res(STATUS_OK, 0, 0, 0, 0, 0));
    add_word(wd(MODE_START, BAND_MASK, 16'hFFFF, 1'b0), 1'b1,
             res(STATUS_BUSY, 0, 0, 0, 0, 0));
    add_word(wd(MODE_DISCOVER, 32'h0, 16'h0, 1'b0), 1'b1, res(STATUS_BUSY, 0, 0, 0, 0, 0));
    add_word(wd(MODE_EVENT, 32'h0, 16'h0, 1'b0), 1'b0, '0);
    add_word(wd(MODE_EVENT, 32'hFFFF_FFFF, 16'hFFFF, 1'b0), 1'b0, '0);
    add_word(wd(MODE_EVENT, 32'h0, 16'h0, 1'b1), 1'b1, res(STATUS_OK, 0, 0, 0, 0, 1));
    add_word(wd(MODE_EVENT, 32'h0, 16'h0, 1'b0), 1'b1, res(STATUS_OK, 0, 0, 0, 0, 1));
    add_word(wd(MODE_START, 32'h1 << 26, 16'hFFFF, 1'b0), 1'b1,
             res(STATUS_OK, 0, 0, 0, 0, 0));
    add_word(wd(MODE_EVENT, 32'h0, 16'h0, 1'b0), 1'b0, '0);
    add_word(wd(MODE_EVENT, 32'h0, 16'h0, 1'b0), 1'b1, res(STATUS_OK, 0, 0, 0, 0, 1));
    // Tick overflow saturates the timer load
    add_cfg(1023);
    add_word(wd(MODE_START, 32'h1 << 11, 16'hFFFF, 1'b0), 1'b1,
             res(STATUS_OK, 0, 0, 0, 0, 0));
    add_word(wd(MODE_EVENT, 32'h0, 16'h0, 1'b0), 1'b1, res(STATUS_OK, 11, 1, 16'hFFFF, 1, 0));
    // Zero tick rate gives a zero timer load
    add_cfg(0);
    add_word(wd(MODE_START, 32'h0000_1800, 16'd2, 1'b0), 1'b1,
             res(STATUS_OK, 0, 0, 0, 0, 0));
    add_word(wd(MODE_EVENT, 32'h0, 16'h0, 1'b0), 1'b1, res(STATUS_OK, 11, 1, 0, 1, 0));
    add_word(wd(MODE_EVENT, 32'h0, 16'h0, 1'b1), 1'b1, res(STATUS_OK, 0, 0, 0, 0, 1));
    add_word(wd(MODE_START, BAND_MASK, 16'd0, 1'b0), 1'b1, res(STATUS_SHORT, 0, 0, 0, 0, 0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed rows with no idling
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_tps(dir_rows[i].cfg_val);
      else send_word(dir_rows[i].word, dir_rows[i].lit, dir_rows[i].result);
    end

    // Random phases, each with its own tick rate and idling pattern
    for (p = 0; p < N_PHASES; p++) begin
      v = (ph_tps[p] < 0) ? $urandom_range(1000, 1) : ph_tps[p];
      write_tps(v);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      // hold off the receiver so the block backs up into its input
      if (p == 0) hold_req = 400;
      k = 0;
      while (k < PHASE_WORDS) begin
        w = next_word();
        send_word(w, 1'b0, '0);
        if (w.mode != MODE_NONE) begin
          k++;
          if (p == 5 && k == PHASE_WORDS / 2) drain_results();
        end
      end
    end

    drain_results();
    repeat (40) @(posedge clk);

    $display("Sent %0d request words over %0d tick rates: %0d scans started, %0d aborted.",
             words_sent, rates_used, scans_started, scans_aborted);
    $display("Compared %0d result words, %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("[radio_channel_scan_sequencer] OK");
    end else begin
      $display("[radio_channel_scan_sequencer] ERROR");
    end
    $finish;
  end

endmodule

/* radio_channel_scan_sequencer.f */
rtl/core/rcss_pkg.sv
rtl/core/rcss_div.sv
rtl/core/rcss_dp.sv
rtl/core/rcss_ctrl.sv
rtl/core/radio_channel_scan_sequencer.sv
verif/tb_radio_channel_scan_sequencer.sv
